@@ hdl/sfpd_pkg.sv @@
// constants and widths shared by the signed fixed-point divider
package sfpd_pkg;

    localparam int FRAC_BITS  = 5;
    localparam int DATA_WIDTH = 32;
    localparam int OUT_WIDTH  = 38;
    localparam int IN_FIELD_W = 32;

    localparam int QUO_W = DATA_WIDTH + FRAC_BITS;
    localparam int MAG_W = (QUO_W > OUT_WIDTH) ? QUO_W : OUT_WIDTH;

    localparam int N_STAGES = QUO_W + 2;

    localparam int S_TDATA_W = 2 * IN_FIELD_W;
    localparam int M_TDATA_W = ((OUT_WIDTH + 7) / 8) * 8;
    localparam int M_TUSER_W = 1;

endpackage

@@ hdl/signed_fixed_point_divider_core.sv @@
// pipelined signed fixed-point divider, one restoring step per stage
//
// Usage:
//   Input beats arrive on s_tvalid/s_tready/s_tdata, carrying a signed
//   dividend and divisor. Each input beat yields one output beat on
//   m_tvalid/m_tready/m_tdata/m_tuser holding the signed quotient scaled
//   by 2^FRAC_BITS, truncated toward zero, plus a divide-by-zero flag.
//   A zero divisor raises the flag and returns a zero quotient.
// Pipeline: an operand-magnitude stage, one restoring subtract and
//   compare stage per quotient bit, then a sign and zero-divisor
//   selection stage.
// Throughput: one beat per cycle while the output is not stalled; each
//   stage holds its own beat, so a new pair enters every cycle while the
//   stages ahead keep moving.
// Reset: aresetn (synchronous, active low) empties every stage.
// Stall: when m_tready is low the output beat is held; stages behind it
//   keep filling empty slots, and s_tready falls only once every stage
//   is occupied. Nothing is lost or repeated.
module signed_fixed_point_divider_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [31:0] dividend, [63:32] divisor
    input  logic [sfpd_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [37:0] quotient_scaled, [39:38] zero padding
    output logic [sfpd_pkg::M_TDATA_W-1:0]  m_tdata,
    // [0] divide_by_zero
    output logic [sfpd_pkg::M_TUSER_W-1:0]  m_tuser
);
    import sfpd_pkg::*;

    localparam int LAST = N_STAGES - 1;

    logic                  valid_reg [0:LAST];
    logic                  adv       [0:LAST];
    logic                  neg_reg   [0:QUO_W];
    logic                  dz_reg    [0:QUO_W];
    logic [DATA_WIDTH-1:0] den_reg   [0:QUO_W];
    logic [DATA_WIDTH-1:0] rem_reg   [0:QUO_W];
    logic [QUO_W-1:0]      nq_reg    [0:QUO_W];

    logic [OUT_WIDTH-1:0]  quo_reg;
    logic                  flag_reg;

    // handshake: a stage moves when it is empty or the next one moves
    assign adv[LAST] = !valid_reg[LAST] || m_tready;
    genvar g;
    generate
        for (g = 0; g < LAST; g++) begin : g_adv
            assign adv[g] = !valid_reg[g] || adv[g+1];
        end
    endgenerate

    assign s_tready = adv[0];
    assign m_tvalid = valid_reg[LAST];
    assign m_tdata  = M_TDATA_W'(quo_reg);
    assign m_tuser  = M_TUSER_W'(flag_reg);

    generate
        for (g = 0; g < N_STAGES; g++) begin : g_valid
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[g] <= 1'b0;
                end else if (adv[g]) begin
                    if (g == 0) begin
                        valid_reg[g] <= s_tvalid;
                    end else begin
                        valid_reg[g] <= valid_reg[(g == 0) ? 0 : g-1];
                    end
                end
            end
        end
    endgenerate

    // operand magnitudes
    logic [DATA_WIDTH-1:0] num_raw, den_raw, num_mag, den_mag;
    logic                  num_neg, den_neg;

    always_comb begin
        num_raw = s_tdata[DATA_WIDTH-1:0];
        den_raw = s_tdata[IN_FIELD_W+DATA_WIDTH-1:IN_FIELD_W];
        num_neg = num_raw[DATA_WIDTH-1];
        den_neg = den_raw[DATA_WIDTH-1];
        num_mag = num_neg ? (~num_raw + 1'b1) : num_raw;
        den_mag = den_neg ? (~den_raw + 1'b1) : den_raw;
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            neg_reg[0] <= num_neg ^ den_neg;
            dz_reg[0]  <= (den_raw == '0);
            den_reg[0] <= den_mag;
            rem_reg[0] <= '0;
            nq_reg[0]  <= QUO_W'(num_mag) << FRAC_BITS;
        end
    end

    // restoring steps, numerator bits shift out as quotient bits shift in
    generate
        for (g = 1; g <= QUO_W; g++) begin : g_step
            logic [DATA_WIDTH:0]   trial;
            logic [DATA_WIDTH:0]   diff;
            logic                  fits;
            logic [DATA_WIDTH-1:0] rem_next;
            logic [QUO_W-1:0]      nq_next;

            always_comb begin
                trial    = {rem_reg[g-1], nq_reg[g-1][QUO_W-1]};
                diff     = trial - {1'b0, den_reg[g-1]};
                fits     = !diff[DATA_WIDTH];
                rem_next = fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
                nq_next  = {nq_reg[g-1][QUO_W-2:0], fits};
            end

            always_ff @(posedge aclk) begin
                if (adv[g]) begin
                    neg_reg[g] <= neg_reg[g-1];
                    dz_reg[g]  <= dz_reg[g-1];
                    den_reg[g] <= den_reg[g-1];
                    rem_reg[g] <= rem_next;
                    nq_reg[g]  <= nq_next;
                end
            end
        end
    endgenerate

    // sign and zero-divisor selection
    logic [MAG_W-1:0]     mag_ext;
    logic [MAG_W-1:0]     signed_val;
    logic [OUT_WIDTH-1:0] quo_next;

    always_comb begin
        mag_ext    = MAG_W'(nq_reg[QUO_W]);
        signed_val = neg_reg[QUO_W] ? (~mag_ext + 1'b1) : mag_ext;
        quo_next   = dz_reg[QUO_W] ? '0 : signed_val[OUT_WIDTH-1:0];
    end

    always_ff @(posedge aclk) begin
        if (adv[LAST]) begin
            quo_reg  <= quo_next;
            flag_reg <= dz_reg[QUO_W];
        end
    end

`ifndef NO_ASSERTIONS
    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[OUT_WIDTH-1:0] == '0)
        else $error("zero divisor gave a nonzero quotient");

    a_ready_when_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output stage");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid straight after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output beat changed");
`endif

endmodule
